### sv/cif_pkg.sv
// cif_pkg: shared types, constants and saturation helpers of the integrate-and-fire block
// depends on nothing; imported by cif_frame_state and integrate_and_fire_aggregator_core

package cif_pkg;

   localparam int IDX_W    = 9;   // element index width
   localparam int WEIGHT_W = 17;  // unsigned Q0.16 / Q1.16 weight fields
   localparam int HIDDEN_W = 16;  // signed Q3.12 encoder value
   localparam int LEVEL_W  = 19;  // signed Q2.16 integration level
   localparam int USED_W   = 18;  // signed Q1.16 used and leftover weight
   localparam int ACC_W    = 32;  // signed Q3.28 accumulator
   localparam int PROD_W   = USED_W + HIDDEN_W;
   localparam int WIDE_W   = 21;  // working width of the weight arithmetic

   localparam logic [WEIGHT_W-1:0]      ONE_WEIGHT = 17'd65536;
   localparam logic signed [WIDE_W-1:0] ONE_WIDE   = 21'sd65536;

   // register map of the csr port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_WEIGHT    = 1'd1;

   localparam logic [WEIGHT_W-1:0] FIRE_THRESHOLD_RST = 17'd65536;
   localparam logic [WEIGHT_W-1:0] TAIL_WEIGHT_RST    = 17'd29491;

   typedef struct packed {
      logic                     fires;
      logic signed [USED_W-1:0] used;
      logic signed [USED_W-1:0] leftover;
   } frame_ctl_type;

   // clamp to the signed 19-bit level range
   function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [WIDE_W-1:0] v);
      logic signed [LEVEL_W-1:0] r;
      if (v[WIDE_W-1:LEVEL_W-1] == {(WIDE_W-LEVEL_W+1){v[WIDE_W-1]}}) begin
         r = v[LEVEL_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(LEVEL_W-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp to the signed 18-bit weight range
   function automatic logic signed [USED_W-1:0] sat_weight(input logic signed [WIDE_W-1:0] v);
      logic signed [USED_W-1:0] r;
      if (v[WIDE_W-1:USED_W-1] == {(WIDE_W-USED_W+1){v[WIDE_W-1]}}) begin
         r = v[USED_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(USED_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(USED_W-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp to the signed 32-bit accumulator range
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W:0] v);
      logic signed [ACC_W-1:0] r;
      if (v[PROD_W:ACC_W-1] == {(PROD_W-ACC_W+2){v[PROD_W]}}) begin
         r = v[ACC_W-1:0];
      end else if (v[PROD_W]) begin
         r = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(ACC_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### sv/integrate_and_fire_aggregator_core.sv
// integrate_and_fire_aggregator_core: top level of the integrate-and-fire aggregator
// depends on cif_pkg and cif_frame_state

// Continuous integrate-and-fire aggregator. One encoder element is taken as a word on the req_
// channel each cycle; element 0 of a frame carries the frame weight, which is added to the
// integration level and split into a used part and, when the frame fires, a leftover part.
// Every element adds used weight times value to its accumulator; on a firing frame the
// accumulator goes out as one rsp_ word and restarts at leftover times value. Elements with
// an index of VECTOR_DIM or more are taken and dropped. The block sustains one word per
// cycle: a word goes through an input stage (frame split and accumulator read) and a second
// stage (multiply, add, saturate, write back), so a result passes the second-stage registers
// and the output register before it is offered on rsp_, and back-pressure on rsp_ only stalls
// req_ once the output register and the second stage are both full. The accumulator store is
// one VECTOR_DIM-entry memory with one write and one registered read a cycle; back-to-back
// words to the same element are forwarded. After reset a clearing pass zeroes the store one
// entry a cycle, holding req_ready low until the last entry is cleared; csr_ writes are taken
// throughout.

module integrate_and_fire_aggregator_core
   import cif_pkg::*;
#(
   parameter int VECTOR_DIM = 512
) (
   input  logic                     clock,
   input  logic                     reset,

   // element words in
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IDX_W-1:0]         req_element_index,
   input  logic [WEIGHT_W-1:0]      req_frame_weight,
   input  logic signed [HIDDEN_W-1:0] req_hidden_value,
   input  logic                     req_tail_frame,

   // embedding words out
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ACC_W-1:0]  rsp_embedding_value,
   output logic [IDX_W-1:0]         rsp_embedding_index,
   output logic                     rsp_embedding_last,

   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [WEIGHT_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
   localparam int IXW_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
   localparam int CMP_W  = IXW_W + 1;

   // ---------------- configuration registers ----------------
   logic [WEIGHT_W-1:0] threshold_ff, threshold_in;
   logic [WEIGHT_W-1:0] tail_weight_ff, tail_weight_in;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in   = threshold_ff;
      tail_weight_in = tail_weight_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRE_THRESHOLD: threshold_in   = csr_wdata;
            CSR_TAIL_WEIGHT:    tail_weight_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= FIRE_THRESHOLD_RST;
         tail_weight_ff <= TAIL_WEIGHT_RST;
      end else begin
         threshold_ff   <= threshold_in;
         tail_weight_ff <= tail_weight_in;
      end
   end

   // ---------------- clearing pass after reset ----------------
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(VECTOR_DIM - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // ---------------- input stage ----------------
   logic              req_take;     // handshake completes
   logic              req_keep;     // taken and in range
   logic [IXW_W-1:0]  req_idx_wide;
   logic [ADDR_W-1:0] req_addr;
   logic              req_in_range;
   logic              req_last;
   frame_ctl_type     req_ctl;

   assign req_take     = req_valid & req_ready;
   assign req_idx_wide = IXW_W'(req_element_index);
   assign req_addr     = req_idx_wide[ADDR_W-1:0];
   assign req_in_range = CMP_W'(req_element_index) < CMP_W'(VECTOR_DIM);
   assign req_last     = CMP_W'(req_element_index) == CMP_W'(VECTOR_DIM - 1);
   assign req_keep     = req_take & req_in_range;

   cif_frame_state u_frame_state (
      .clock          (clock),
      .reset          (reset),
      .start_frame    (req_keep && (req_element_index == '0)),
      .tail           (req_tail_frame),
      .frame_weight   (req_frame_weight),
      .fire_threshold (threshold_ff),
      .tail_weight    (tail_weight_ff),
      .ctl            (req_ctl)
   );

   // ---------------- second stage registers ----------------
   logic                       s1_valid_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [IDX_W-1:0]           s1_idx_ff;
   logic                       s1_last_ff;
   logic signed [HIDDEN_W-1:0] s1_hidden_ff;
   frame_ctl_type              s1_ctl_ff;
   logic                       s1_advance;

   logic                       rsp_valid_ff;
   logic signed [ACC_W-1:0]    rsp_value_ff;
   logic [IDX_W-1:0]           rsp_index_ff;
   logic                       rsp_last_ff;

   // a non-firing word leaves no result, so it never waits on the output
   assign s1_advance = s1_valid_ff & (~s1_ctl_ff.fires | ~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~clr_busy_ff & (~s1_valid_ff | s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= req_in_range;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_keep) begin
         s1_addr_ff   <= req_addr;
         s1_idx_ff    <= req_element_index;
         s1_last_ff   <= req_last;
         s1_hidden_ff <= req_tail_frame ? '0 : req_hidden_value;
         s1_ctl_ff    <= req_ctl;
      end
   end

   // ---------------- accumulator store ----------------
   logic signed [ACC_W-1:0] acc_mem [VECTOR_DIM];
   logic signed [ACC_W-1:0] rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic signed [ACC_W-1:0] mem_wdata;
   logic signed [ACC_W-1:0] acc_new;

   assign mem_we    = clr_busy_ff | s1_advance;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : acc_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_waddr] <= mem_wdata;
      end
      if (req_keep) begin
         rd_data_ff <= acc_mem[req_addr];
      end
   end

   // latest write back, forwarded when the read raced it
   logic                    fwd_valid_ff;
   logic [ADDR_W-1:0]       fwd_addr_ff;
   logic signed [ACC_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= acc_new;
      end
   end

   // ---------------- multiply, accumulate, saturate ----------------
   logic signed [ACC_W-1:0]  acc_old;
   logic signed [PROD_W-1:0] prod_used;
   logic signed [PROD_W-1:0] prod_left;
   logic signed [PROD_W:0]   acc_sum_w;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  acc_restart;

   always_comb begin
      acc_old     = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data_ff;
      prod_used   = s1_ctl_ff.used * s1_hidden_ff;
      prod_left   = s1_ctl_ff.leftover * s1_hidden_ff;
      acc_sum_w   = (PROD_W + 1)'(acc_old) + (PROD_W + 1)'(prod_used);
      acc_sum     = sat_acc(acc_sum_w);
      acc_restart = sat_acc((PROD_W + 1)'(prod_left));
      // a firing element hands out its sum and restarts from the leftover share
      acc_new     = s1_ctl_ff.fires ? acc_restart : acc_sum;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_ctl_ff.fires) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_ctl_ff.fires) begin
         rsp_value_ff <= acc_sum;
         rsp_index_ff <= s1_idx_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_embedding_value = rsp_value_ff;
   assign rsp_embedding_index = rsp_index_ff;
   assign rsp_embedding_last  = rsp_last_ff;

endmodule

### sv/cif_frame_state.sv
// cif_frame_state: integration level and per-frame weight split
// depends on cif_pkg

module cif_frame_state
   import cif_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start_frame,     // accepted element 0
   input  logic                tail,
   input  logic [WEIGHT_W-1:0] frame_weight,
   input  logic [WEIGHT_W-1:0] fire_threshold,
   input  logic [WEIGHT_W-1:0] tail_weight,
   output frame_ctl_type       ctl
);

   logic signed [LEVEL_W-1:0] level_ff, level_in;
   frame_ctl_type             frame_ff, frame_in;

   logic [WEIGHT_W-1:0]       alpha_raw;
   logic [WEIGHT_W-1:0]       alpha;
   logic signed [WIDE_W-1:0]  level_ext;
   logic signed [WIDE_W-1:0]  alpha_ext;
   logic signed [WIDE_W-1:0]  required_w;
   logic signed [WIDE_W-1:0]  sum_w;
   logic signed [WIDE_W-1:0]  left_w;
   logic signed [WIDE_W-1:0]  drop_w;
   logic signed [USED_W-1:0]  required;
   logic signed [LEVEL_W-1:0] level_sum;

   always_comb begin
      alpha_raw  = tail ? tail_weight : frame_weight;
      alpha      = (alpha_raw > ONE_WEIGHT) ? ONE_WEIGHT : alpha_raw;
      level_ext  = WIDE_W'(level_ff);
      alpha_ext  = $signed({{(WIDE_W-WEIGHT_W){1'b0}}, alpha});
      required_w = ONE_WIDE - level_ext;
      required   = sat_weight(required_w);
      sum_w      = level_ext + alpha_ext;
      level_sum  = sat_level(sum_w);
      left_w     = alpha_ext - WIDE_W'(required);
      drop_w     = WIDE_W'(level_sum) - ONE_WIDE;

      frame_in.fires = WIDE_W'(level_sum)
                       >= $signed({{(WIDE_W-WEIGHT_W){1'b0}}, fire_threshold});
      if (frame_in.fires) begin
         frame_in.used     = required;
         frame_in.leftover = sat_weight(left_w);
         level_in          = sat_level(drop_w);
      end else begin
         frame_in.used     = USED_W'(alpha_ext);
         frame_in.leftover = '0;
         level_in          = level_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         frame_ff <= '0;
      end else if (start_frame) begin
         level_ff <= level_in;
         frame_ff <= frame_in;
      end
   end

   // element 0 sees its own frame's split, later elements the stored one
   assign ctl = start_frame ? frame_in : frame_ff;

endmodule
